FILE: hdl/aips_pkg.sv
package aips_pkg;

   // Parse phases, one-hot.
   typedef enum logic [4:0] {
      PH_SPACE      = 5'b00001,
      PH_PREFIX     = 5'b00010,
      PH_AFTER_ZERO = 5'b00100,
      PH_DIGITS     = 5'b01000,
      PH_DONE       = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       negative;
      logic [5:0] base;
   } ctl_type;

   localparam int unsigned RADIX_BITS = 6;
   localparam int unsigned CHAR_BITS  = 8;
   localparam int unsigned HALF_BITS  = 64;
   localparam int unsigned VALUE_BITS = 128;
   localparam int unsigned CNT_OUT_BITS = 32;
   localparam int unsigned RSP_BITS   = VALUE_BITS + CNT_OUT_BITS;

   localparam logic [5:0] RADIX_MIN   = 6'd2;
   localparam logic [5:0] RADIX_MAX   = 6'd36;
   localparam logic [5:0] BASE_BIN    = 6'd2;
   localparam logic [5:0] BASE_OCT    = 6'd8;
   localparam logic [5:0] BASE_DEC    = 6'd10;
   localparam logic [5:0] BASE_HEX    = 6'd16;
   localparam logic [5:0] DIGIT_NONE  = 6'd63;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7a;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5a;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;

   function automatic logic [5:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
         return d[5:0];
      end
      if (c >= CH_LA && c <= CH_LZ) begin
         d = c - CH_LA + 8'd10;
         return d[5:0];
      end
      if (c >= CH_UA && c <= CH_UZ) begin
         d = c - CH_UA + 8'd10;
         return d[5:0];
      end
      return DIGIT_NONE;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

FILE: hdl/aips_step.sv
module aips_step #(
   parameter int unsigned ACC_BITS   = 128,
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic                    first,
   input  logic [7:0]              ch,
   input  logic [5:0]              radix,
   input  aips_pkg::ctl_type       ctl,
   input  logic [ACC_BITS-1:0]     acc,
   input  logic [COUNT_BITS-1:0]   count,
   output aips_pkg::ctl_type       ctl_next,
   output logic [ACC_BITS-1:0]     acc_next,
   output logic [COUNT_BITS-1:0]   count_next,
   output logic                    emit,
   output logic [aips_pkg::VALUE_BITS-1:0] value
);

   localparam int unsigned PW = ACC_BITS + 6;
   localparam logic [ACC_BITS-1:0] MAG_MIN = ACC_BITS'(1) << (ACC_BITS - 1);
   localparam logic [ACC_BITS-1:0] MAG_MAX = MAG_MIN - ACC_BITS'(1);

   aips_pkg::phase_type   ph;
   logic                  neg;
   logic [5:0]            wb;
   logic [ACC_BITS-1:0]   a;
   logic [COUNT_BITS-1:0] c;
   logic                  go;
   logic                  bump;
   logic                  sat;
   logic [5:0]            dig;
   logic [PW-1:0]         prod;
   logic [ACC_BITS-1:0]   lim;
   logic [ACC_BITS-1:0]   a_neg;
   logic [ACC_BITS-1:0]   res;
   logic                  radix_ok;

   assign dig      = aips_pkg::digit_value(ch);
   assign radix_ok = (radix >= aips_pkg::RADIX_MIN) && (radix <= aips_pkg::RADIX_MAX);

   always_comb begin
      ph   = first ? aips_pkg::PH_SPACE : ctl.phase;
      neg  = first ? 1'b0 : ctl.negative;
      wb   = first ? 6'd0 : ctl.base;
      a    = first ? '0 : acc;
      c    = first ? '0 : count;
      go   = 1'b1;
      bump = 1'b0;
      sat  = 1'b0;
      emit = 1'b0;
      prod = '0;
      acc_next = a;

      if (ph == aips_pkg::PH_SPACE) begin
         priority if (aips_pkg::is_space(ch)) begin
            bump = 1'b1;
            go   = 1'b0;
         end else if (ch == aips_pkg::CH_MINUS || ch == aips_pkg::CH_PLUS) begin
            neg  = (ch == aips_pkg::CH_MINUS);
            bump = 1'b1;
            ph   = aips_pkg::PH_PREFIX;
            go   = 1'b0;
         end else begin
            ph = aips_pkg::PH_PREFIX;
         end
      end

      if (go && ph == aips_pkg::PH_PREFIX) begin
         priority if (radix_ok) begin
            wb = radix;
            ph = aips_pkg::PH_DIGITS;
         end else if (ch == aips_pkg::CH_ZERO) begin
            bump = 1'b1;
            ph   = aips_pkg::PH_AFTER_ZERO;
            go   = 1'b0;
         end else begin
            wb = aips_pkg::BASE_DEC;
            ph = aips_pkg::PH_DIGITS;
         end
      end

      if (go && ph == aips_pkg::PH_AFTER_ZERO) begin
         priority if (ch == aips_pkg::CH_LX || ch == aips_pkg::CH_UX) begin
            wb   = aips_pkg::BASE_HEX;
            bump = 1'b1;
            go   = 1'b0;
         end else if (ch == aips_pkg::CH_LB || ch == aips_pkg::CH_UB) begin
            wb   = aips_pkg::BASE_BIN;
            bump = 1'b1;
            go   = 1'b0;
         end else begin
            wb = aips_pkg::BASE_OCT;
         end
         ph = aips_pkg::PH_DIGITS;
      end

      lim = neg ? MAG_MIN : MAG_MAX;

      if (go && ph == aips_pkg::PH_DIGITS) begin
         prod = PW'(a) * PW'(wb) + PW'(dig);
         priority if (dig >= wb) begin
            emit = 1'b1;
         end else if (prod[PW-1:ACC_BITS] != '0 || prod[ACC_BITS-1:0] > lim) begin
            // The digit would push the magnitude past the signed range.
            emit = 1'b1;
            sat  = 1'b1;
         end else begin
            acc_next = prod[ACC_BITS-1:0];
            bump     = 1'b1;
         end
         if (emit) begin
            ph = aips_pkg::PH_DONE;
         end
      end

      ctl_next.phase    = ph;
      ctl_next.negative = neg;
      ctl_next.base     = wb;
      count_next        = (bump && c != '1) ? c + COUNT_BITS'(1) : c;
   end

   // The negated accumulator comes straight from state, off the multiply path.
   // The negated negative limit is the limit itself in ACC_BITS bits.
   assign a_neg = '0 - a;
   assign res   = sat ? lim : (neg ? a_neg : a);
   assign value = aips_pkg::VALUE_BITS'(signed'(res));

endmodule

FILE: hdl/ascii_integer_parser_saturating_unit.sv
// Streaming ASCII to signed integer converter. Each req beat carries one character (tdata) and
// a start-of-string flag (tuser); leading whitespace, one sign and, when csr_wdata is outside
// 2..36, a 0x/0b/0 base prefix are accepted, then digits are accumulated with saturation at the
// signed ACC_BITS range. The first character that is not taken (NUL included) produces one rsp
// beat with the value sign-extended to 128 bits and the count of characters taken; characters
// after it are dropped until the next start flag. One character is accepted every clock cycle
// unless the input stalls: each beat passes an input register, one pass of the per-character
// step (a multiply of the accumulator by the base, an add and a limit compare) and the result
// register, whose valid flag drives rsp_tvalid. While a result waits in the output register,
// only a held character that would produce another result stalls the input.
// Write csr_wdata only while idle.
module ascii_integer_parser_saturating_unit #(
   parameter int unsigned ACC_BITS   = 128,
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [5:0]   csr_wdata,   // radix
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // ch
   input  logic [0:0]   req_tuser,   // first
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata    // value_low, value_high, consumed_count
);

   logic [5:0]            radix_ff;
   logic                  in_valid_ff;
   logic                  in_first_ff;
   logic [7:0]            in_ch_ff;
   aips_pkg::ctl_type     ctl_ff;
   aips_pkg::ctl_type     ctl_in;
   logic [ACC_BITS-1:0]   acc_ff;
   logic [ACC_BITS-1:0]   acc_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  rsp_valid_ff;
   logic [aips_pkg::RSP_BITS-1:0] rsp_data_ff;
   logic [aips_pkg::VALUE_BITS-1:0] value;
   logic                  emit;
   logic                  out_free;
   logic                  fire;
   logic                  out_load;
   logic                  req_beat;

   aips_step #(
      .ACC_BITS   (ACC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .first      (in_first_ff),
      .ch         (in_ch_ff),
      .radix      (radix_ff),
      .ctl        (ctl_ff),
      .acc        (acc_ff),
      .count      (count_ff),
      .ctl_next   (ctl_in),
      .acc_next   (acc_in),
      .count_next (count_in),
      .emit       (emit),
      .value      (value)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   // A held character that yields no result moves on even while the output is full.
   assign fire       = in_valid_ff && (out_free || !emit);
   assign out_load   = fire && emit;
   assign req_tready = !in_valid_ff || fire;
   assign req_beat   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
      end else if (csr_we) begin
         radix_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_beat) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_first_ff <= req_tuser[0];
         in_ch_ff    <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.phase    <= aips_pkg::PH_SPACE;
         ctl_ff.negative <= 1'b0;
         ctl_ff.base     <= '0;
         acc_ff          <= '0;
         count_ff        <= '0;
      end else if (fire) begin
         ctl_ff   <= ctl_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {aips_pkg::CNT_OUT_BITS'(count_ff & {COUNT_BITS{!in_first_ff}}), value};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_done_after_result: assert property (@(posedge clock) disable iff (reset)
      out_load |=> ctl_ff.phase == aips_pkg::PH_DONE)
      else $error("phase is not finished after a result beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register loaded while a result is still pending");

   a_done_is_silent: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_first_ff && ctl_ff.phase == aips_pkg::PH_DONE |-> !emit)
      else $error("a second result was produced for one string");

   a_beat_held: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> in_valid_ff)
      else $error("accepted character not held in the input register");

endmodule
